// ----- hdl/fifo_or_sorted_priority_queue_top_defines.svh -----
// Assertion macros for the FIFO or sorted priority queue.
// Used by the top level only; depends on a clock named clock and a reset named reset.
`ifndef FIFO_OR_SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define FIFO_OR_SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSPQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/fspq_pkg.sv -----
// Shared types and codes for the FIFO or sorted priority queue.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package fspq_pkg;

   localparam int KEY_W    = 32;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 4;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [KIND_W-1:0]       kind_type;
   typedef logic [STATUS_W-1:0]     status_type;
   typedef logic [OCC_W-1:0]        occ_type;

   // Operation codes.
   localparam kind_type KIND_INSERT = 2'd0;
   localparam kind_type KIND_DELETE = 2'd1;
   localparam kind_type KIND_PEEK   = 2'd2;

   // Result status codes.
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_OVERFLOW  = 2'd1;
   localparam status_type ST_UNDERFLOW = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PUT,
      S_DEL_DATA,
      S_PEEK_HEAD,
      S_PEEK_TAIL,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

// ----- hdl/fspq_channels.sv -----
// Valid/ready channel interfaces for requests, responses and the mode register.
// Depends on fspq_pkg for the payload types.
`default_nettype none

interface fspq_req_if;
   import fspq_pkg::*;
   logic     valid;
   logic     ready;
   kind_type kind;
   key_type  key;
   modport source (output valid, output kind, output key, input ready);
   modport sink (input valid, input kind, input key, output ready);
endinterface

interface fspq_rsp_if;
   import fspq_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   key_type    head_value;
   key_type    tail_value;
   occ_type    occupancy;
   modport source (output valid, output status, output head_value, output tail_value,
                   output occupancy, input ready);
   modport sink (input valid, input status, input head_value, input tail_value,
                 input occupancy, output ready);
endinterface

interface fspq_csr_if;
   logic valid;
   logic ready;
   logic priority_mode;
   modport source (output valid, output priority_mode, input ready);
   modport sink (input valid, input priority_mode, output ready);
endinterface

`default_nettype wire

// ----- hdl/fifo_or_sorted_priority_queue_top.sv -----
// Bounded queue of signed keys, FIFO or ascending sorted, one transaction at a time.
// Kind 3 and errors go straight to the response stage; a FIFO insert writes its key, a
// delete reads the next head, a peek reads the head and then the tail, and a priority insert
// searches k keys and then shifts s keys. The single memory port and its registered read pace each step.
// A new request is taken the cycle after the response is registered in the output stage.
// Synchronous active-high reset empties the queue and selects FIFO mode; no memory clear.
`default_nettype none
`include "fifo_or_sorted_priority_queue_top_defines.svh"

module fifo_or_sorted_priority_queue_top #(
   parameter int DEPTH = 8
) (
   input  wire logic  clock,
   input  wire logic  reset,
   fspq_req_if.sink   req_ch,
   fspq_rsp_if.source rsp_ch,
   fspq_csr_if.sink   csr_ch
);
   import fspq_pkg::*;

   // Address width of the key store and width of the key count (which can reach DEPTH).
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Sequencer and queue bookkeeping.
   state_type     state_ff, state_in;
   logic          mode_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   // Scan index and insertion position, both logical offsets from the head.
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;

   // Key being inserted and the result being built.
   key_type    key_ff, key_in;
   status_type status_ff, status_in;
   key_type    head_val_ff, head_val_in;
   key_type    tail_val_ff, tail_val_in;

   // Output stage: holds a finished response until the consumer takes it.
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   key_type    rsp_head_ff, rsp_head_in;
   key_type    rsp_tail_ff, rsp_tail_in;
   occ_type    rsp_occ_ff, rsp_occ_in;

   // Key store: one shared address per cycle, registered read data.
   key_type mem [DEPTH];
   key_type rd_data_ff;
   logic    wr_en;
   key_type wr_data;

   // Shared address unit: maps a logical offset from the head onto a physical slot.
   // The offset is always below DEPTH, so one compare and subtract wraps it.
   logic [CW-1:0] logical;
   logic [CW:0]   slot_sum;
   logic [AW-1:0] slot;

   assign slot_sum = (CW+1)'(head_ff) + (CW+1)'(logical);
   assign slot     = (slot_sum >= (CW+1)'(DEPTH)) ? AW'(slot_sum - (CW+1)'(DEPTH))
                                                  : AW'(slot_sum);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[slot] <= wr_data;
      end
      rd_data_ff <= mem[slot];
   end

   // Mode register: always ready, unguarded; the user must write it only while the queue is idle.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         mode_ff <= csr_ch.priority_mode;
      end
   end

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.head_value = rsp_head_ff;
   assign rsp_ch.tail_value = rsp_tail_ff;
   assign rsp_ch.occupancy  = rsp_occ_ff;

   // Sequencer. A priority insert first scans forward from the head for the first
   // key greater than the new one, then moves the keys from the tail down to that
   // position one place back, one read and one write per key, and finally writes
   // the new key into the gap. Equal keys are passed over, so the new key lands
   // after them.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      head_val_in   = head_val_ff;
      tail_val_in   = tail_val_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_tail_in   = rsp_tail_ff;
      rsp_occ_in    = rsp_occ_ff;
      logical       = '0;
      wr_en         = 1'b0;
      wr_data       = key_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            // Offset zero reads the head key, ready for a delete or a peek.
            if (req_ch.valid) begin
               key_in      = req_ch.key;
               status_in   = ST_OK;
               head_val_in = '0;
               tail_val_in = '0;
               unique case (req_ch.kind)
                  KIND_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = ST_OVERFLOW;
                        state_in  = S_RESP;
                     end else if (mode_ff && (count_ff != '0)) begin
                        idx_in   = '0;
                        state_in = S_SRCH_RD;
                     end else begin
                        pos_in   = count_ff;
                        state_in = S_PUT;
                     end
                  end
                  KIND_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = ST_UNDERFLOW;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_DEL_DATA;
                     end
                  end
                  KIND_PEEK: begin
                     if (count_ff == '0) begin
                        status_in = ST_UNDERFLOW;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_PEEK_HEAD;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SRCH_RD: begin
            logical  = idx_ff;
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (key_ff < rd_data_ff) begin
               pos_in   = idx_ff;
               idx_in   = count_ff;
               state_in = S_SHIFT_RD;
            end else if ((idx_ff + CW'(1)) == count_ff) begin
               pos_in   = count_ff;
               state_in = S_PUT;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SRCH_RD;
            end
         end
         S_SHIFT_RD: begin
            logical  = idx_ff - CW'(1);
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            logical = idx_ff;
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
            idx_in  = idx_ff - CW'(1);
            if ((idx_ff - CW'(1)) == pos_ff) begin
               state_in = S_PUT;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_PUT: begin
            logical  = pos_ff;
            wr_en    = 1'b1;
            wr_data  = key_ff;
            count_in = count_ff + CW'(1);
            state_in = S_RESP;
         end
         S_DEL_DATA: begin
            // Offset one gives the next head; an emptied queue restarts at slot zero.
            logical     = CW'(1);
            head_val_in = rd_data_ff;
            count_in    = count_ff - CW'(1);
            head_in     = (count_ff == CW'(1)) ? '0 : slot;
            state_in    = S_RESP;
         end
         S_PEEK_HEAD: begin
            logical     = count_ff - CW'(1);
            head_val_in = rd_data_ff;
            state_in    = S_PEEK_TAIL;
         end
         S_PEEK_TAIL: begin
            tail_val_in = rd_data_ff;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_head_in   = head_val_ff;
               rsp_tail_in   = tail_val_ff;
               rsp_occ_in    = OCC_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      status_ff     <= status_in;
      head_val_ff   <= head_val_in;
      tail_val_ff   <= tail_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_tail_ff   <= rsp_tail_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // The key count never exceeds the store depth.
   `FSPQ_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CW'(DEPTH), "key count above depth")
   // An empty queue always has its head at slot zero.
   `FSPQ_ASSERT_SAME(a_empty_head, count_ff == '0, head_ff == '0, "empty queue head not zero")
   // Every shift step writes to a slot that lies behind the insertion position.
   `FSPQ_ASSERT_SAME(a_shift_range, state_ff == S_SHIFT_WR, idx_ff > pos_ff, "shift past insert")
   // Overflow is reported only for a full queue.
   `FSPQ_ASSERT_SAME(a_overflow_full, rsp_ch.valid && (rsp_ch.status == ST_OVERFLOW),
      rsp_ch.occupancy == OCC_W'(DEPTH), "overflow reported when not full")
   // A request taken in a cycle leaves the sequencer busy in the next.
   `FSPQ_ASSERT_NEXT(a_busy_after_accept, req_ch.valid && req_ch.ready, state_ff != S_IDLE,
      "sequencer idle after accepting a transaction")

endmodule

`default_nettype wire

// ----- verif/fifo_or_sorted_priority_queue_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the FIFO or sorted priority queue: directed table, then random traffic.
// Depends on fspq_pkg, the channel interfaces in fspq_channels.sv and the queue top level.

module fifo_or_sorted_priority_queue_top_tb;
   import fspq_pkg::*;

   localparam int QUEUE_DEPTH     = 8;
   localparam int ITEMS_PER_PHASE = 170;
   localparam int DRAIN_CYCLES    = 4 * QUEUE_DEPTH + 8;
   // The slowest operation is a priority insert into a nearly full queue. With about 700 transactions
   // and long random stalls on both sides this limit is far above any correct run.
   localparam int CYCLE_LIMIT     = 1_000_000;

   // The package names three operations; the fourth code is a no-op.
   localparam kind_type KIND_UNUSED = 2'd3;

   localparam logic FIFO_MODE = 1'b0;
   localparam logic PRIO_MODE = 1'b1;
   localparam logic TYPED     = 1'b1;
   localparam logic PREDICTED = 1'b0;

   typedef struct packed {
      status_type status;
      key_type    head_value;
      key_type    tail_value;
      occ_type    occupancy;
   } queue_rsp_type;

   localparam queue_rsp_type NO_WANT = '0;

   // One row of the directed table. Rows marked TYPED carry the response that
   // the block must return; the rest are checked against the queue predictor.
   typedef struct packed {
      logic          mode;
      kind_type      kind;
      key_type       key;
      logic          typed;
      queue_rsp_type want;
   } dir_row_type;

   localparam int DIR_ROWS = 24;

   logic clock = 1'b0;
   logic reset;

   fspq_req_if req_if ();
   fspq_rsp_if rsp_if ();
   fspq_csr_if csr_if ();

   fifo_or_sorted_priority_queue_top #(
      .DEPTH(QUEUE_DEPTH)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_ch(csr_if)
   );

   always #5 clock = ~clock;

   // Predictor state: the circular key store, its head slot, the key count and
   // the mode register as the bench last wrote it.
   key_type model_keys [QUEUE_DEPTH];
   int      model_head;
   int      model_count;
   logic    prio_mode;

   queue_rsp_type pending_results [$];
   int            mismatch_count;
   int            cycle_count;
   int            sender_idle_pct;
   int            rsp_stall_pct;

   dir_row_type dir_table [0:DIR_ROWS-1];

   function automatic int model_slot(input int logical);
      return (model_head + logical) % QUEUE_DEPTH;
   endfunction

   // Applies one operation to the predictor state and returns the response it owes.
   function automatic queue_rsp_type predict_queue_op(input kind_type kind, input key_type key);
      queue_rsp_type res;
      int            pos;
      res = '0;
      pos = model_count;
      case (kind)
         KIND_INSERT: begin
            if (model_count >= QUEUE_DEPTH) begin
               res.status = ST_OVERFLOW;
            end else begin
               if (prio_mode) begin
                  // The new key goes before the first held key greater than it,
                  // so equal keys keep their arrival order.
                  for (int i = 0; i < model_count; i++)
                     if (pos == model_count && key < model_keys[model_slot(i)])
                        pos = i;
                  for (int i = model_count; i > pos; i--)
                     model_keys[model_slot(i)] = model_keys[model_slot(i - 1)];
               end
               model_keys[model_slot(pos)] = key;
               model_count++;
            end
         end
         KIND_DELETE: begin
            if (model_count == 0) begin
               res.status = ST_UNDERFLOW;
            end else begin
               res.head_value = model_keys[model_head];
               model_count--;
               // An emptied queue starts over at slot zero.
               model_head = (model_count == 0) ? 0 : (model_head + 1) % QUEUE_DEPTH;
            end
         end
         KIND_PEEK: begin
            if (model_count == 0) begin
               res.status = ST_UNDERFLOW;
            end else begin
               res.head_value = model_keys[model_head];
               res.tail_value = model_keys[model_slot(model_count - 1)];
            end
         end
         default: ;
      endcase
      res.occupancy = occ_type'(model_count);
      return res;
   endfunction

   // Random operation mix. A fill bias drives the queue into overflow, a drain
   // bias into underflow, so both ends of the occupancy range are visited often.
   function automatic kind_type pick_kind(input logic fill_bias);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 4)
         return KIND_UNUSED;
      else if (roll < 18)
         return KIND_PEEK;
      else if (roll < (fill_bias ? 70 : 42))
         return KIND_INSERT;
      else
         return KIND_DELETE;
   endfunction

   // Keys: the two extremes, a narrow band that produces many equal keys, and
   // fully random patterns that toggle every bit.
   function automatic key_type pick_key();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3, 4: return key_type'($urandom_range(0, 12)) - 32'sd6;
         default: return key_type'($urandom);
      endcase
   endfunction

   // Offers one transaction, with random idle cycles ahead of it, and records
   // the expected response once the block has taken it.
   task automatic issue_request(input kind_type kind, input key_type key,
                                input logic use_typed, input queue_rsp_type typed_rsp);
      queue_rsp_type predicted;
      while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind  <= kind;
      req_if.key   <= key;
      @(posedge clock);
      while (req_if.ready !== 1'b1)
         @(posedge clock);
      predicted = predict_queue_op(kind, key);
      pending_results.push_back(use_typed ? typed_rsp : predicted);
   endtask

   // Stops offering requests until every outstanding response has come back.
   task automatic stop_and_drain();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Writes the mode register; only called while the block is idle.
   task automatic write_priority_mode(input logic mode);
      csr_if.valid         <= 1'b1;
      csr_if.priority_mode <= mode;
      @(posedge clock);
      while (csr_if.ready !== 1'b1)
         @(posedge clock);
      csr_if.valid <= 1'b0;
      prio_mode = mode;
   endtask

   // Compares one accepted response with the oldest expectation.
   task automatic check_response();
      queue_rsp_type want;
      if (pending_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("[%0t] response with no transaction outstanding: status %0d head %0d",
                     $realtime, rsp_if.status, rsp_if.head_value);
      end else begin
         want = pending_results.pop_front();
         if (rsp_if.status !== want.status || rsp_if.head_value !== want.head_value ||
             rsp_if.tail_value !== want.tail_value || rsp_if.occupancy !== want.occupancy) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display({"[%0t] mismatch: expected status %0d head %0d tail %0d occ %0d,",
                         " got status %0d head %0d tail %0d occ %0d"},
                        $realtime, want.status, want.head_value, want.tail_value,
                        want.occupancy, rsp_if.status, rsp_if.head_value,
                        rsp_if.tail_value, rsp_if.occupancy);
         end
      end
   endtask

   // Response side: a response is taken at an edge where valid and ready were
   // both high, and ready for the next cycle is drawn against the stall rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            check_response();
         rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("fifo_or_sorted_priority_queue_top verification failed");
         $finish;
      end
   end

   initial begin
      int   r;
      int   phase;
      int   n;
      logic fill_bias;

      // Every block input is known from time zero.
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.kind          = KIND_INSERT;
      req_if.key           = '0;
      csr_if.valid         = 1'b0;
      csr_if.priority_mode = FIFO_MODE;
      rsp_if.ready         = 1'b0;
      mismatch_count       = 0;
      cycle_count          = 0;
      sender_idle_pct      = 0;
      rsp_stall_pct        = 0;
      model_head           = 0;
      model_count          = 0;
      prio_mode            = FIFO_MODE;
      fill_bias            = 1'b1;
      foreach (model_keys[i])
         model_keys[i] = '0;

      // Directed part. The FIFO rows cover both underflows, the no-op, an insert
      // and delete that empties the queue, the key extremes, filling to overflow
      // and a wrap of the ring. The mode then switches with seven keys held, so
      // the priority rows sort into a wrapped, unsorted store.
      dir_table = '{
         '{FIFO_MODE, KIND_PEEK,   32'sh0F0F_0F0F, TYPED,
           '{ST_UNDERFLOW, 32'sh0, 32'sh0, 4'd0}},
         '{FIFO_MODE, KIND_DELETE, 32'sh0F0F_0F0F, TYPED,
           '{ST_UNDERFLOW, 32'sh0, 32'sh0, 4'd0}},
         '{FIFO_MODE, KIND_UNUSED, 32'sh7FFF_FFFF, TYPED,
           '{ST_OK, 32'sh0, 32'sh0, 4'd0}},
         '{FIFO_MODE, KIND_INSERT, 32'sh7FFF_FFFF, TYPED,
           '{ST_OK, 32'sh0, 32'sh0, 4'd1}},
         '{FIFO_MODE, KIND_DELETE, 32'sh0F0F_0F0F, TYPED,
           '{ST_OK, 32'sh7FFF_FFFF, 32'sh0, 4'd0}},
         '{FIFO_MODE, KIND_INSERT, 32'sh8000_0000, TYPED,
           '{ST_OK, 32'sh0, 32'sh0, 4'd1}},
         '{FIFO_MODE, KIND_INSERT, 32'sh7FFF_FFFF, TYPED,
           '{ST_OK, 32'sh0, 32'sh0, 4'd2}},
         '{FIFO_MODE, KIND_PEEK,   32'sh0,         TYPED,
           '{ST_OK, 32'sh8000_0000, 32'sh7FFF_FFFF, 4'd2}},
         '{FIFO_MODE, KIND_INSERT, -32'sd1,        PREDICTED, NO_WANT},
         '{FIFO_MODE, KIND_INSERT, 32'sh0,         PREDICTED, NO_WANT},
         '{FIFO_MODE, KIND_INSERT, 32'sd1,         PREDICTED, NO_WANT},
         '{FIFO_MODE, KIND_INSERT, 32'sh5555_5555, PREDICTED, NO_WANT},
         '{FIFO_MODE, KIND_INSERT, 32'shAAAA_AAAA, PREDICTED, NO_WANT},
         '{FIFO_MODE, KIND_INSERT, 32'sd3,         PREDICTED, NO_WANT},
         '{FIFO_MODE, KIND_INSERT, 32'sd9,         TYPED,
           '{ST_OVERFLOW, 32'sh0, 32'sh0, 4'd8}},
         '{FIFO_MODE, KIND_DELETE, 32'sh0,         TYPED,
           '{ST_OK, 32'sh8000_0000, 32'sh0, 4'd7}},
         '{FIFO_MODE, KIND_DELETE, 32'sh0,         TYPED,
           '{ST_OK, 32'sh7FFF_FFFF, 32'sh0, 4'd6}},
         '{FIFO_MODE, KIND_INSERT, 32'sd5,         PREDICTED, NO_WANT},
         '{PRIO_MODE, KIND_INSERT, -32'sd7,        PREDICTED, NO_WANT},
         '{PRIO_MODE, KIND_DELETE, 32'sh0,         PREDICTED, NO_WANT},
         '{PRIO_MODE, KIND_INSERT, 32'sh0,         PREDICTED, NO_WANT},
         '{PRIO_MODE, KIND_PEEK,   32'sh0,         PREDICTED, NO_WANT},
         '{PRIO_MODE, KIND_INSERT, 32'sh7FFF_FFFF, PREDICTED, NO_WANT},
         '{PRIO_MODE, KIND_UNUSED, 32'sh0,         PREDICTED, NO_WANT}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < DIR_ROWS; r++) begin
         if (dir_table[r].mode != prio_mode) begin
            stop_and_drain();
            write_priority_mode(dir_table[r].mode);
         end
         issue_request(dir_table[r].kind, dir_table[r].key, dir_table[r].typed,
                       dir_table[r].want);
      end

      // Random part in four phases: no idling, a slow sender, a stalling
      // receiver, and light idling on both sides. The mode alternates from phase
      // to phase while keys stay in the queue. Halfway through each phase the
      // sender holds off until every response is back.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               rsp_stall_pct   = 0;
            end
            1: begin
               sender_idle_pct = 56;
               rsp_stall_pct   = 0;
            end
            2: begin
               sender_idle_pct = 0;
               rsp_stall_pct   = 56;
            end
            default: begin
               sender_idle_pct = 9;
               rsp_stall_pct   = 9;
            end
         endcase
         stop_and_drain();
         write_priority_mode(phase[0] ? PRIO_MODE : FIFO_MODE);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 16 == 0)
               fill_bias = 1'($urandom_range(0, 1));
            if (n == ITEMS_PER_PHASE / 2)
               stop_and_drain();
            issue_request(pick_kind(fill_bias), pick_key(), PREDICTED, NO_WANT);
         end
      end

      // Collect the last responses, then watch a little longer for strays.
      stop_and_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("fifo_or_sorted_priority_queue_top verification clean");
      else
         $display("fifo_or_sorted_priority_queue_top verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/fspq_pkg.sv
hdl/fspq_channels.sv
hdl/fifo_or_sorted_priority_queue_top.sv
verif/fifo_or_sorted_priority_queue_top_tb.sv
